// ===== design/dsrc_pkg.sv =====
// Shared constants and codes for the dirty sector run coalescer.
package dsrc_pkg;

    // Default sizes, handed to the top level parameters
    localparam int MAX_SECTORS_DEF        = 128;
    localparam int ENTRIES_PER_SECTOR_DEF = 128;

    // Field widths fixed by the interface
    localparam int ENTRY_W    = 14;
    localparam int ADDR_W     = 32;
    localparam int FIRST_W    = 7;
    localparam int LEN_W      = 8;
    localparam int COUNT_W    = 8;
    localparam int APB_DATA_W = 32;
    localparam int REG_ADDR_W = 3;

    // Request codes
    localparam logic REQ_MARK  = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // Register reset values
    localparam logic [COUNT_W-1:0] SECTORS_RESET = 8'd128;
    localparam logic [ADDR_W-1:0]  BASE_RESET    = 32'd0;

    // Register map, indexed by paddr[2]
    typedef enum logic {
        REG_SECTORS_IN_USE = 1'b0,
        REG_TABLE_BASE     = 1'b1
    } reg_idx_t;

endpackage

// ===== design/dsrc_req_if.sv =====
// Request channel: mark or flush items.
interface dsrc_req_if import dsrc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [ENTRY_W-1:0] entry_index;

    modport source (output valid, req_type, entry_index, input ready);
    modport sink   (input valid, req_type, entry_index, output ready);
endinterface

// ===== design/dsrc_cmd_if.sv =====
// Command channel: one write command item per dirty run, or one empty item when a flush finds none.
interface dsrc_cmd_if import dsrc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  write_address;
    logic [FIRST_W-1:0] first_sector;
    logic [LEN_W-1:0]   run_length;
    logic               last;

    modport source (output valid, write_address, first_sector, run_length, last, input ready);
    modport sink   (input valid, write_address, first_sector, run_length, last, output ready);
endinterface

// ===== design/dirty_sector_run_coalescer_unit.sv =====
// Top level: dirty sector bitmap with run-coalescing flush.
//
//  channel  dir  flow         payload
//  req      in   valid/ready  req_type, entry_index
//  cmd      out  valid/ready  write_address, first_sector, run_length, last
//  apb      in   psel/penable sectors_in_use @0x0, table_base_address @0x4
//
// A mark: the entry index is multiplied by a reciprocal of ENTRIES_PER_SECTOR
// on accept, and the bit is set in the next cycle.
// A flush is accepted, then walks the sectors in turn, closes each run in a
// step of its own and ends the scan in a final step.
// The scan holds whenever a finished run or the final item must go out and cmd is still full.
// Reset clears the bitmap and the control state at once; no clearing pass.
module dirty_sector_run_coalescer_unit
    import dsrc_pkg::*;
#(
    parameter int MAX_SECTORS        = MAX_SECTORS_DEF,
    parameter int ENTRIES_PER_SECTOR = ENTRIES_PER_SECTOR_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    dsrc_req_if.sink              req,
    dsrc_cmd_if.source            cmd,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W     = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
    localparam int CNT_W     = $clog2(MAX_SECTORS + 1);
    localparam int DIV_SHIFT = ENTRY_W + $clog2(ENTRIES_PER_SECTOR);
    localparam int MULT_W    = ENTRY_W + 1;
    localparam int PROD_W    = ENTRY_W + MULT_W;
    localparam longint DIV_MULT_L =
        ((longint'(1) << DIV_SHIFT) + longint'(ENTRIES_PER_SECTOR) - 1)
        / longint'(ENTRIES_PER_SECTOR);
    localparam logic [MULT_W-1:0]  DIV_MULT  = MULT_W'(DIV_MULT_L);
    localparam logic [ENTRY_W-1:0] LIMIT_MAX = ENTRY_W'(MAX_SECTORS);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SET  = 3'b010,
        ST_SCAN = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   sectors_reg;
    logic [ADDR_W-1:0]    base_reg;
    logic [MAX_SECTORS-1:0] dirty_reg, dirty_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic                 in_run_reg, in_run_next;
    logic [IDX_W-1:0]     run_start_reg, run_start_next;
    logic [CNT_W-1:0]     run_len_reg, run_len_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]     pend_start_reg, pend_start_next;
    logic [CNT_W-1:0]     pend_len_reg, pend_len_next;
    logic                 out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]    out_addr_reg, out_addr_next;
    logic [FIRST_W-1:0]   out_first_reg, out_first_next;
    logic [LEN_W-1:0]     out_len_reg, out_len_next;
    logic                 out_last_reg, out_last_next;

    logic                 cfg_wr;
    logic [ENTRY_W-1:0]   limit_w;
    logic [PROD_W-1:0]    quot_full;
    logic [ENTRY_W-1:0]   cmp_a;
    logic                 cmp_lt;
    logic [IDX_W-1:0]     cur_idx;
    logic                 hit;
    logic                 out_free;

    // Configuration registers
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sectors_reg <= SECTORS_RESET;
            base_reg    <= BASE_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx_t'(paddr[2]))
                REG_SECTORS_IN_USE: sectors_reg <= pwdata[COUNT_W-1:0];
                REG_TABLE_BASE:     base_reg    <= pwdata[ADDR_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[2]))
            REG_SECTORS_IN_USE: prdata = APB_DATA_W'(sectors_reg);
            REG_TABLE_BASE:     prdata = base_reg;
            default:            prdata = '0;
        endcase
    end

    // Effective sector count, saturated at MAX_SECTORS
    assign limit_w = (ENTRY_W'(sectors_reg) > LIMIT_MAX) ? LIMIT_MAX : ENTRY_W'(sectors_reg);

    // Sector of a marked entry: top bits of the reciprocal product
    assign quot_full = prod_reg >> DIV_SHIFT;

    // Shared range compare: marked sector on SET, scan position otherwise
    assign cmp_a   = (state_reg == ST_SET) ? quot_full[ENTRY_W-1:0] : ENTRY_W'(scan_reg);
    assign cmp_lt  = cmp_a < limit_w;
    assign cur_idx = cmp_a[IDX_W-1:0];
    assign hit     = cmp_lt && dirty_reg[cur_idx];

    assign out_free  = !out_valid_reg || cmd.ready;
    assign req.ready = (state_reg == ST_IDLE);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        dirty_next      = dirty_reg;
        prod_next       = prod_reg;
        scan_next       = scan_reg;
        in_run_next     = in_run_reg;
        run_start_next  = run_start_reg;
        run_len_next    = run_len_reg;
        pend_valid_next = pend_valid_reg;
        pend_start_next = pend_start_reg;
        pend_len_next   = pend_len_reg;
        out_valid_next  = out_valid_reg && !cmd.ready;
        out_addr_next   = out_addr_reg;
        out_first_next  = out_first_reg;
        out_len_next    = out_len_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.req_type == REQ_FLUSH)
                    begin
                        scan_next       = '0;
                        in_run_next     = 1'b0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_SCAN;
                    end
                    else
                    begin
                        prod_next  = PROD_W'(req.entry_index) * PROD_W'(DIV_MULT);
                        state_next = ST_SET;
                    end
                end
            end

            ST_SET:
            begin
                if (cmp_lt)
                    dirty_next[cur_idx] = 1'b1;
                state_next = ST_IDLE;
            end

            ST_SCAN:
            begin
                if (hit)
                begin
                    // extend or open a run, clearing the bit as we go
                    dirty_next[cur_idx] = 1'b0;
                    if (!in_run_reg)
                    begin
                        run_start_next = cur_idx;
                        run_len_next   = CNT_W'(1);
                        in_run_next    = 1'b1;
                    end
                    else
                        run_len_next = run_len_reg + CNT_W'(1);
                    scan_next = scan_reg + CNT_W'(1);
                end
                else if (in_run_reg)
                begin
                    // close the run; the previous one is now known not last
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_addr_next  = base_reg + ADDR_W'(pend_start_reg);
                            out_first_next = FIRST_W'(pend_start_reg);
                            out_len_next   = LEN_W'(pend_len_reg);
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_start_next = run_start_reg;
                        pend_len_next   = run_len_reg;
                        in_run_next     = 1'b0;
                    end
                end
                else if (cmp_lt)
                    scan_next = scan_reg + CNT_W'(1);
                else if (out_free)
                begin
                    // end of scan: held run goes out as last, or the empty item
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_addr_next  = base_reg + ADDR_W'(pend_start_reg);
                        out_first_next = FIRST_W'(pend_start_reg);
                        out_len_next   = LEN_W'(pend_len_reg);
                    end
                    else
                    begin
                        out_addr_next  = '0;
                        out_first_next = '0;
                        out_len_next   = '0;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            dirty_reg      <= '0;
            in_run_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            scan_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            dirty_reg      <= dirty_next;
            in_run_reg     <= in_run_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            scan_reg       <= scan_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prod_reg       <= prod_next;
        run_start_reg  <= run_start_next;
        run_len_reg    <= run_len_next;
        pend_start_reg <= pend_start_next;
        pend_len_reg   <= pend_len_next;
        out_addr_reg   <= out_addr_next;
        out_first_reg  <= out_first_next;
        out_len_reg    <= out_len_next;
        out_last_reg   <= out_last_next;
    end

    assign cmd.valid         = out_valid_reg;
    assign cmd.write_address = out_addr_reg;
    assign cmd.first_sector  = out_first_reg;
    assign cmd.run_length    = out_len_reg;
    assign cmd.last          = out_last_reg;

    // Checks
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.run_length == '0 |-> cmd.last)
        else $error("empty flush item without last");

    a_addr_matches: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.run_length != '0 |->
            cmd.write_address == base_reg + ADDR_W'(cmd.first_sector))
        else $error("write address does not match first sector");

    a_oob_mark_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SET && !cmp_lt |=> dirty_reg == $past(dirty_reg))
        else $error("out of range mark changed the bitmap");

    a_run_start_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && in_run_reg |-> !dirty_reg[run_start_reg])
        else $error("open run start still dirty");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid |-> ENTRY_W'(cmd.run_length) <= limit_w)
        else $error("run longer than sector count");

    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> state_reg == ST_SCAN)
        else $error("held run outside a flush");

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the dirty sector run coalescer: directed, pressure and random traffic.
`timescale 1ns / 100ps

module tb
    import dsrc_pkg::*;
();

    typedef struct packed {
        logic [ADDR_W-1:0]  write_address;
        logic [FIRST_W-1:0] first_sector;
        logic [LEN_W-1:0]   run_length;
        logic               last;
    } wr_cmd_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [REG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    dsrc_req_if req_ch ();
    dsrc_cmd_if cmd_ch ();

    // Shadow of the block: bitmap and registers
    bit                 dirty_map [MAX_SECTORS_DEF];
    logic [COUNT_W-1:0] sect_count = SECTORS_RESET;
    logic [ADDR_W-1:0]  base_addr  = BASE_RESET;

    wr_cmd_t pending_cmds [$];
    int      err_count      = 0;
    bit      tx_idle_on     = 1'b1;
    bit      rx_idle_on     = 1'b1;
    int      rx_hold_cycles = 0;

    dirty_sector_run_coalescer_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .cmd     (cmd_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Run limit
    initial
    begin
        #50_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int active_limit();
        return (int'(sect_count) > MAX_SECTORS_DEF) ? MAX_SECTORS_DEF : int'(sect_count);
    endfunction

    // Random entry inside the given sector
    function automatic logic [ENTRY_W-1:0] entry_in(input int sector);
        return ENTRY_W'(sector * ENTRIES_PER_SECTOR_DEF
                        + $urandom_range(0, ENTRIES_PER_SECTOR_DEF - 1));
    endfunction

    function automatic void note_mark(input logic [ENTRY_W-1:0] entry);
        int sector;
        sector = int'(entry) / ENTRIES_PER_SECTOR_DEF;
        if (sector < active_limit())
            dirty_map[sector] = 1'b1;
    endfunction

    // Scan the shadow bitmap, queue one write command per dirty run
    function automatic void expect_flush_cmds();
        int      lim;
        int      i;
        int      run;
        bit      have_run;
        wr_cmd_t held;
        lim      = active_limit();
        have_run = 1'b0;
        held     = '0;
        i        = 0;
        while (i < lim)
        begin
            if (dirty_map[i])
            begin
                run = 0;
                while (i + run < lim && dirty_map[i + run])
                begin
                    dirty_map[i + run] = 1'b0;
                    run++;
                end
                if (have_run)
                    pending_cmds.push_back(held);
                held.write_address = base_addr + ADDR_W'(i);
                held.first_sector  = FIRST_W'(i);
                held.run_length    = LEN_W'(run);
                held.last          = 1'b0;
                have_run           = 1'b1;
                i += run;
            end
            else
                i++;
        end
        // nothing dirty: one empty command
        if (!have_run)
            held = '0;
        held.last = 1'b1;
        pending_cmds.push_back(held);
    endfunction

    // Send one request item; valid stays up after acceptance so a
    // back-to-back item needs no second assignment in the same step
    task automatic send_item(input logic kind, input logic [ENTRY_W-1:0] entry);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.entry_index <= entry;
        do
            @(posedge clk);
        while (!(req_ch.valid === 1'b1 && req_ch.ready === 1'b1));
        if (kind == REQ_FLUSH)
            expect_flush_cmds();
        else
            note_mark(entry);
    endtask

    task automatic send_mark(input int sector);
        send_item(REQ_MARK, entry_in(sector));
    endtask

    task automatic send_flush();
        send_item(REQ_FLUSH, ENTRY_W'($urandom));
    endtask

    // Stop offering, wait for all commands, let a pending mark settle
    task automatic wait_drain();
        req_ch.valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // APB write: setup then access; only while the block is idle
    task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        wait_drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_SECTORS_IN_USE)
            sect_count = value[COUNT_W-1:0];
        else
            base_addr = value[ADDR_W-1:0];
    endtask

    // Command receiver: random stalls, plus a counted hold-off on request
    initial
    begin : cmd_receiver
        int stall_left;
        stall_left = 0;
        cmd_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                cmd_ch.ready <= 1'b0;
                rx_hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                cmd_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                cmd_ch.ready <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 3) == 0)
                    stall_left = gap_len();
            end
        end
    end

    function automatic void check_field(input string fname, input logic [ADDR_W-1:0] want,
                                        input logic [ADDR_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
            err_count++;
        end
    endfunction

    // Compare each accepted command with the oldest expected one
    always @(posedge clk)
    begin : cmd_checker
        wr_cmd_t want;
        if (cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1)
        begin
            if (pending_cmds.size() == 0)
            begin
                $display("%0t: unexpected command, expected none actual addr %0h first %0d len %0d",
                         $time, cmd_ch.write_address, cmd_ch.first_sector, cmd_ch.run_length);
                err_count++;
            end
            else
            begin
                want = pending_cmds.pop_front();
                check_field("write_address", want.write_address, cmd_ch.write_address);
                check_field("first_sector", ADDR_W'(want.first_sector),
                            ADDR_W'(cmd_ch.first_sector));
                check_field("run_length", ADDR_W'(want.run_length), ADDR_W'(cmd_ch.run_length));
                check_field("last", ADDR_W'(want.last), ADDR_W'(cmd_ch.last));
            end
        end
    end

    // Empty flush, entry extremes, runs at both ends of the table
    task automatic test_basic_runs();
        send_flush();
        send_item(REQ_MARK, 14'd0);
        send_item(REQ_MARK, 14'd127);
        send_item(REQ_MARK, 14'd128);
        send_item(REQ_MARK, 14'h3FFF);
        send_item(REQ_MARK, 14'd640);
        send_flush();
        send_flush();
    endtask

    // Zero sectors, saturated count, single sector, address wrap
    task automatic test_register_extremes();
        write_reg(REG_SECTORS_IN_USE, 32'd0);
        send_item(REQ_MARK, 14'd0);
        send_flush();
        write_reg(REG_SECTORS_IN_USE, 32'd255);
        send_item(REQ_MARK, 14'h3FFF);
        send_flush();
        write_reg(REG_SECTORS_IN_USE, 32'd1);
        send_item(REQ_MARK, 14'd128);
        send_item(REQ_MARK, 14'd5);
        send_flush();
        write_reg(REG_TABLE_BASE, 32'hFFFF_FFFF);
        write_reg(REG_SECTORS_IN_USE, 32'd129);
        send_item(REQ_MARK, 14'd0);
        send_item(REQ_MARK, 14'd16256);
        send_flush();
    endtask

    // Bits above a lowered count stay set until the count is raised
    task automatic test_lowered_count();
        write_reg(REG_SECTORS_IN_USE, 32'd128);
        write_reg(REG_TABLE_BASE, 32'h0000_1000);
        send_mark(5);
        send_mark(100);
        write_reg(REG_SECTORS_IN_USE, 32'd10);
        send_mark(50);
        send_flush();
        write_reg(REG_SECTORS_IN_USE, 32'd128);
        send_flush();
    endtask

    // One run over the whole table, then alternating sectors on a short table
    task automatic test_table_extremes();
        int s;
        write_reg(REG_SECTORS_IN_USE, 32'd128);
        write_reg(REG_TABLE_BASE, 32'h8000_0000);
        for (s = MAX_SECTORS_DEF - 1; s >= 0; s--)
            send_mark(s);
        send_flush();
        write_reg(REG_SECTORS_IN_USE, 32'd16);
        write_reg(REG_TABLE_BASE, 32'hFFFF_FFFC);
        for (s = 0; s < 16; s += 2)
            send_mark(s);
        send_flush();
    endtask

    // Receiver holds off while requests keep coming, then the sender drains
    task automatic test_backpressure();
        int s;
        write_reg(REG_SECTORS_IN_USE, 32'd128);
        write_reg(REG_TABLE_BASE, $urandom);
        tx_idle_on     = 1'b0;
        rx_idle_on     = 1'b0;
        rx_hold_cycles = 400;
        repeat (2)
        begin
            for (s = 0; s < 12; s += 2)
                send_mark(s + $urandom_range(0, 1));
            send_flush();
        end
        wait_drain();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Phases of random register settings; mostly clustered marks then a flush
    task automatic test_random_traffic();
        int                    n_sent;
        int                    phase;
        int                    phase_sent;
        int                    lim;
        int                    start;
        int                    len;
        int                    s;
        int                    r;
        logic [COUNT_W-1:0]    count_val;
        logic [APB_DATA_W-1:0] wval;
        n_sent = 0;
        phase  = 0;
        while (n_sent < 36)
        begin
            case ($urandom_range(0, 7))
                0:       count_val = 8'd0;
                1:       count_val = 8'd1;
                2:       count_val = 8'($urandom_range(2, 8));
                3:       count_val = 8'd128;
                4:       count_val = 8'($urandom_range(129, 255));
                default: count_val = 8'($urandom_range(1, 128));
            endcase
            wval          = $urandom;
            wval[7:0]     = count_val;
            write_reg(REG_SECTORS_IN_USE, wval);
            case ($urandom_range(0, 3))
                0:       write_reg(REG_TABLE_BASE, 32'd0);
                1:       write_reg(REG_TABLE_BASE, 32'hFFFF_FFFF);
                default: write_reg(REG_TABLE_BASE, $urandom);
            endcase
            // every second phase runs without idling
            tx_idle_on = (phase % 2 == 0);
            rx_idle_on = tx_idle_on;
            lim        = active_limit();
            phase_sent = 0;
            while (phase_sent < 12)
            begin
                r = $urandom_range(0, 9);
                if (r < 7 && lim > 0)
                begin
                    start = $urandom_range(0, lim - 1);
                    len   = $urandom_range(1, (lim - start < 6) ? lim - start : 6);
                    for (s = start; s < start + len; s++)
                        send_mark(s);
                    phase_sent += len;
                    if ($urandom_range(0, 9) < 7)
                    begin
                        send_flush();
                        phase_sent++;
                    end
                end
                else if (r < 9)
                begin
                    send_item(REQ_MARK, ENTRY_W'($urandom));
                    phase_sent++;
                end
                else
                begin
                    send_flush();
                    phase_sent++;
                end
            end
            n_sent += phase_sent;
            phase++;
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial
    begin : main_seq
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_MARK;
        req_ch.entry_index <= '0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_basic_runs();
        test_register_extremes();
        test_lowered_count();
        test_table_extremes();
        test_backpressure();
        test_random_traffic();
        wait_drain();

        if (err_count == 0 && pending_cmds.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/dsrc_pkg.sv
design/dsrc_req_if.sv
design/dsrc_cmd_if.sv
design/dirty_sector_run_coalescer_unit.sv
tb/sv/tb.sv
